FILE: rtl/cfc_pkg.sv
// Shared types and constants for the causal FIR convolution block.
`timescale 1ns / 1ps

package cfc_pkg;

  localparam int TAPS     = 64;
  localparam int IDX_W    = $clog2(TAPS);
  localparam int TAPCNT_W = 7;
  localparam int INDEX_W  = 6;
  localparam int COEF_W   = 18;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int ACC_W    = 41;

  // compare widths for tap enable and load address match
  localparam int CMP_W   = (IDX_W > TAPCNT_W) ? IDX_W : TAPCNT_W;
  localparam int MATCH_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = TAPCNT_W'(64);

  // stream packing
  localparam int IN_DATA_W      = INDEX_W + COEF_W + SAMPLE_W;
  localparam int IN_USER_W      = 2;
  localparam int OUT_DATA_W     = ((ACC_W + 7) / 8) * 8;
  localparam int TAP_INDEX_LSB  = 0;
  localparam int COEF_LSB       = TAP_INDEX_LSB + INDEX_W;
  localparam int SAMPLE_LSB     = COEF_LSB + COEF_W;
  localparam int USER_OP_BIT    = 0;
  localparam int USER_FRAME_BIT = 1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } cfc_op_t;

  // what travels from one cell to the next each cycle the chain advances
  typedef struct packed {
    logic                       valid;
    cfc_op_t                    op;
    logic [INDEX_W-1:0]         tap_index;
    logic signed [COEF_W-1:0]   coefficient;
    logic [SAMPLE_W-1:0]        carry;       // sample shifted toward the next cell
    logic                       frame_start;
    logic signed [PROD_W-1:0]   prod;        // product of the previous cell
    logic signed [ACC_W-1:0]    acc;         // partial sum of earlier cells
  } cfc_token_t;

endpackage

FILE: rtl/cfc_tap_cell.sv
// One tap of the FIR chain: holds one coefficient and one history sample.
`timescale 1ns / 1ps

module cfc_tap_cell import cfc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [TAPCNT_W-1:0] tap_count,
  input  logic [IDX_W-1:0]    cell_idx,
  input  cfc_token_t          tok_i,
  output cfc_token_t          tok_o
);

  logic signed [COEF_W-1:0] coef_r, coef_nxt;
  logic [SAMPLE_W-1:0]      hist_r, hist_nxt;
  cfc_token_t               tok_r, tok_nxt;
  logic                     tap_used;
  logic                     load_hit;
  logic signed [PROD_W-1:0] coef_ext;
  logic signed [PROD_W-1:0] sample_ext;

  always_comb begin
    tap_used   = CMP_W'(tap_count) > CMP_W'(cell_idx);
    load_hit   = tok_i.valid && (tok_i.op == OP_LOAD) &&
                 (MATCH_W'(tok_i.tap_index) == MATCH_W'(cell_idx));
    coef_ext   = PROD_W'(coef_r);
    sample_ext = PROD_W'(tok_i.carry);

    coef_nxt = coef_r;
    hist_nxt = hist_r;
    tok_nxt  = tok_i;

    if (load_hit) begin
      coef_nxt = tok_i.coefficient;
    end

    if (tok_i.valid && (tok_i.op == OP_SAMPLE)) begin
      hist_nxt      = tok_i.carry;
      // frame start: everything older than the new sample reads as zero
      tok_nxt.carry = tok_i.frame_start ? '0 : hist_r;
      tok_nxt.acc   = tok_i.acc + ACC_W'(tok_i.prod);
      tok_nxt.prod  = tap_used ? (coef_ext * sample_ext) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      hist_r <= '0;
      tok_r  <= '0;
    end else if (advance) begin
      coef_r <= coef_nxt;
      hist_r <= hist_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: rtl/cfc_out_stage.sv
// Final add and output register of the FIR chain.
`timescale 1ns / 1ps

module cfc_out_stage import cfc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfc_token_t              tok_i,
  input  logic                    out_ready,
  output logic                    advance,
  output logic                    out_valid,
  output logic signed [ACC_W-1:0] filtered
);

  logic                    valid_r, valid_nxt;
  logic signed [ACC_W-1:0] data_r, data_nxt;

  always_comb begin
    advance   = !valid_r || out_ready;
    valid_nxt = tok_i.valid && (tok_i.op == OP_SAMPLE);
    data_nxt  = tok_i.acc + ACC_W'(tok_i.prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign filtered  = data_r;

endmodule

FILE: rtl/causal_fir_convolution.sv
// A sample transaction passes one register per tap cell, then the final add,
//   into the output register.
// Throughput: one transaction per cycle, loads and samples alike; the whole chain stalls
//   only while the output register holds a result that is not taken.
// Reset (synchronous, rst_n low): kernel and history cleared to zero, tap_count = 64,
//   chain and output emptied. No clearing pass; the block is ready the cycle after reset.
`timescale 1ns / 1ps

module causal_fir_convolution import cfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // config: tap_count
  input  logic                  cfg_wr_en,
  input  logic [TAPCNT_W-1:0]   cfg_wr_data,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // tap_index[5:0], coefficient[23:6], sample[39:24]
  input  logic [IN_USER_W-1:0]  in_tuser,   // op[0], frame_start[1]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // filtered[40:0], zero pad above
);

  // Systolic direct-form FIR. Every transaction enters cell 0 as a token and
  // moves one cell per cycle whenever the chain advances. A load token writes
  // the coefficient of the matching cell as it passes; a sample token shifts
  // the history by one cell as it passes and picks up each cell's product on
  // the way. Because loads and samples walk the chain in order, each sample
  // sees exactly the kernel and history that were current when it was accepted.
  //
  // Per cell the product is registered into the token and added by the next
  // cell, so each stage holds one 18x16 multiply and one 41-bit add side by side, never in series.

  logic [TAPCNT_W-1:0]     tap_count_r;
  logic                    advance;
  logic signed [ACC_W-1:0] filtered;
  cfc_token_t              chain [TAPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RESET;
    end else if (cfg_wr_en) begin
      tap_count_r <= cfg_wr_data;
    end
  end

  // chain only moves when the output register can take what falls out
  assign in_tready = advance;

  always_comb begin
    chain[0].valid       = in_tvalid;
    chain[0].op          = cfc_op_t'(in_tuser[USER_OP_BIT]);
    chain[0].frame_start = in_tuser[USER_FRAME_BIT];
    chain[0].tap_index   = in_tdata[TAP_INDEX_LSB +: INDEX_W];
    chain[0].coefficient = in_tdata[COEF_LSB +: COEF_W];
    chain[0].carry       = in_tdata[SAMPLE_LSB +: SAMPLE_W];
    chain[0].prod        = '0;
    chain[0].acc         = '0;
  end

  for (genvar g = 0; g < TAPS; g++) begin : g_tap
    cfc_tap_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .tap_count (tap_count_r),
      .cell_idx  (IDX_W'(g)),
      .tok_i     (chain[g]),
      .tok_o     (chain[g+1])
    );
  end

  cfc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_i     (chain[TAPS]),
    .out_ready (out_tready),
    .advance   (advance),
    .out_valid (out_tvalid),
    .filtered  (filtered)
  );

  assign out_tdata = {{(OUT_DATA_W - ACC_W){1'b0}}, filtered};

endmodule

FILE: rtl/cfc_checker.sv
// Port-level checks for the causal FIR convolution block, bound to its top level.
`timescale 1ns / 1ps

module cfc_checker import cfc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_wr_en,
  input logic [TAPCNT_W-1:0]   cfg_wr_data,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // with the output register empty the chain always moves
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready with empty output");

  // a stalled result freezes the chain
  a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  // no result straight out of reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // the result pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_DATA_W-1:ACC_W] == '0))
    else $error("nonzero pad in result");

endmodule

bind causal_fir_convolution cfc_checker u_cfc_checker (.*);
